@@ rtl/nec_pkg.sv @@
// Shared types, constants and timing helpers for the NEC IR frame decoder.
package nec_pkg;

  localparam int TIME_W      = 15;
  localparam int CODE_W      = 16;
  localparam int COUNT_W     = 6;
  localparam int NUM_REGS    = 8;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;
  localparam int TIME_MARGIN = 200;

  localparam logic [TIME_W:0]    MARGIN       = (TIME_W + 1)'(TIME_MARGIN);
  localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
  localparam logic [COUNT_W-1:0] FRAME_PAIRS  = COUNT_W'(34);
  localparam logic [COUNT_W-1:0] REPEAT_PAIRS = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] LAST_BIT     = COUNT_W'(2 * CODE_W);

  localparam logic [2:0] REG_LEADER_MARK  = 3'd0;
  localparam logic [2:0] REG_LEADER_SPACE = 3'd1;
  localparam logic [2:0] REG_ZERO_MARK    = 3'd2;
  localparam logic [2:0] REG_ZERO_SPACE   = 3'd3;
  localparam logic [2:0] REG_ONE_MARK     = 3'd4;
  localparam logic [2:0] REG_ONE_SPACE    = 3'd5;
  localparam logic [2:0] REG_REPEAT_MARK  = 3'd6;
  localparam logic [2:0] REG_REPEAT_SPACE = 3'd7;

  localparam logic [TIME_W-1:0] REG_RESET [NUM_REGS] = '{
    15'd9000, 15'd4500, 15'd560, 15'd560, 15'd560, 15'd1690, 15'd9000, 15'd2250
  };

  localparam logic [2:0] STATUS_FRAME_OK       = 3'd0;
  localparam logic [2:0] STATUS_REPEAT_OK      = 3'd1;
  localparam logic [2:0] STATUS_FRAME_REJECT   = 3'd2;
  localparam logic [2:0] STATUS_REPEAT_REJECT  = 3'd3;
  localparam logic [2:0] STATUS_UNKNOWN_LENGTH = 3'd4;

  typedef struct packed {
    logic [TIME_W-1:0] mark_time;
    logic [TIME_W-1:0] space_time;
    logic              end_of_frame;
  } pair_t;

  typedef struct packed {
    logic [2:0]        frame_status;
    logic [CODE_W-1:0] ir_address;
    logic [CODE_W-1:0] ir_command;
  } result_t;

  typedef struct packed {
    logic [TIME_W-1:0] leader_mark;
    logic [TIME_W-1:0] leader_space;
    logic [TIME_W-1:0] zero_mark;
    logic [TIME_W-1:0] zero_space;
    logic [TIME_W-1:0] one_mark;
    logic [TIME_W-1:0] one_space;
    logic [TIME_W-1:0] repeat_mark;
    logic [TIME_W-1:0] repeat_space;
  } cfg_t;

  // strictly inside (ref_time - MARGIN, ref_time + MARGIN); a negative low bound passes
  function automatic logic time_match(logic [TIME_W-1:0] t, logic [TIME_W-1:0] ref_time);
    logic [TIME_W:0] t_ext;
    logic [TIME_W:0] r_ext;
    t_ext = {1'b0, t};
    r_ext = {1'b0, ref_time};
    return (t_ext < r_ext + MARGIN) && (t_ext + MARGIN > r_ext);
  endfunction

endpackage

@@ rtl/nec_cfg.sv @@
// APB register file holding the reference timings.
module nec_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nec_pkg::ADDR_W-1:0]  paddr,
  input  logic [nec_pkg::DATA_W-1:0]  pwdata,
  output logic [nec_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output nec_pkg::cfg_t               cfg
);
  import nec_pkg::*;

  logic [TIME_W-1:0] times [NUM_REGS];
  logic [2:0]        index;
  logic              write_en;

  assign index    = paddr[ADDR_W-1:2];
  assign write_en = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign prdata   = {{(DATA_W - TIME_W){1'b0}}, times[index]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        times[i] <= REG_RESET[i];
      end
    end else if (write_en) begin
      times[index] <= pwdata[TIME_W-1:0];
    end
  end

  assign cfg.leader_mark  = times[REG_LEADER_MARK];
  assign cfg.leader_space = times[REG_LEADER_SPACE];
  assign cfg.zero_mark    = times[REG_ZERO_MARK];
  assign cfg.zero_space   = times[REG_ZERO_SPACE];
  assign cfg.one_mark     = times[REG_ONE_MARK];
  assign cfg.one_space    = times[REG_ONE_SPACE];
  assign cfg.repeat_mark  = times[REG_REPEAT_MARK];
  assign cfg.repeat_space = times[REG_REPEAT_SPACE];

endmodule

@@ rtl/nec_core.sv @@
// Frame state, pair classification and the result register.
module nec_core (
  input  logic              clk,
  input  logic              rst,
  input  nec_pkg::cfg_t     cfg,
  input  logic              item_valid,
  input  nec_pkg::pair_t    item,
  output logic              item_take,
  output logic              result_valid,
  input  logic              result_ready,
  output nec_pkg::result_t  result
);
  import nec_pkg::*;

  logic [COUNT_W-1:0] pair_count;
  logic               leader_matched;
  logic               repeat_matched;
  logic               bit_error;
  logic [CODE_W-1:0]  address_shift;
  logic [CODE_W-1:0]  command_shift;
  logic [CODE_W-1:0]  saved_address;
  logic [CODE_W-1:0]  saved_command;

  logic               is_leader;
  logic               is_repeat;
  logic               is_one;
  logic               is_zero;
  logic               in_bits;
  logic [COUNT_W-1:0] bit_pos;
  logic [COUNT_W-1:0] len;
  logic               leader_next;
  logic               repeat_next;
  logic               bit_error_next;
  logic [CODE_W-1:0]  address_next;
  logic [CODE_W-1:0]  command_next;
  logic [2:0]         status_next;

  assign item_take = item_valid && (!result_valid || result_ready);

  assign is_leader = time_match(item.mark_time, cfg.leader_mark)
                  && time_match(item.space_time, cfg.leader_space);
  assign is_repeat = time_match(item.mark_time, cfg.repeat_mark)
                  && time_match(item.space_time, cfg.repeat_space);
  assign is_one    = time_match(item.mark_time, cfg.one_mark)
                  && time_match(item.space_time, cfg.one_space);
  assign is_zero   = time_match(item.mark_time, cfg.zero_mark)
                  && time_match(item.space_time, cfg.zero_space);

  assign in_bits = (pair_count != '0) && (pair_count <= LAST_BIT);
  assign bit_pos = pair_count - COUNT_W'(1);
  assign len     = (pair_count == COUNT_MAX) ? COUNT_MAX : pair_count + COUNT_W'(1);

  always_comb begin
    leader_next    = leader_matched;
    repeat_next    = repeat_matched;
    bit_error_next = bit_error;
    address_next   = address_shift;
    command_next   = command_shift;
    if (pair_count == '0) begin
      leader_next = is_leader;
      repeat_next = is_repeat;
    end else if (in_bits) begin
      if (!is_one && !is_zero) begin
        bit_error_next = 1'b1;
      end
      if (bit_pos[4]) begin
        command_next[bit_pos[3:0]] = is_one;
      end else begin
        address_next[bit_pos[3:0]] = is_one;
      end
    end
  end

  always_comb begin
    if (len == FRAME_PAIRS) begin
      status_next = (leader_next && !bit_error_next) ? STATUS_FRAME_OK : STATUS_FRAME_REJECT;
    end else if (len == REPEAT_PAIRS) begin
      status_next = repeat_next ? STATUS_REPEAT_OK : STATUS_REPEAT_REJECT;
    end else begin
      status_next = STATUS_UNKNOWN_LENGTH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_count     <= '0;
      leader_matched <= 1'b0;
      repeat_matched <= 1'b0;
      bit_error      <= 1'b0;
      address_shift  <= '0;
      command_shift  <= '0;
      saved_address  <= '0;
      saved_command  <= '0;
      result_valid   <= 1'b0;
    end else begin
      result_valid <= (item_take && item.end_of_frame) || (result_valid && !result_ready);
      if (item_take) begin
        if (item.end_of_frame) begin
          pair_count     <= '0;
          leader_matched <= 1'b0;
          repeat_matched <= 1'b0;
          bit_error      <= 1'b0;
          address_shift  <= '0;
          command_shift  <= '0;
          if (status_next == STATUS_FRAME_OK) begin
            saved_address <= address_next;
            saved_command <= command_next;
          end
        end else begin
          pair_count     <= len;
          leader_matched <= leader_next;
          repeat_matched <= repeat_next;
          bit_error      <= bit_error_next;
          address_shift  <= address_next;
          command_shift  <= command_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && item.end_of_frame) begin
      result.frame_status <= status_next;
      if (status_next == STATUS_FRAME_OK) begin
        result.ir_address <= address_next;
        result.ir_command <= command_next;
      end else begin
        result.ir_address <= saved_address;
        result.ir_command <= saved_command;
      end
    end
  end

  a_count_clears: assert property (@(posedge clk) disable iff (rst)
    item_take && item.end_of_frame |=> pair_count == '0)
    else $error("pair count not cleared after final pair");

  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    item_take && !item.end_of_frame && pair_count != COUNT_MAX
    |=> pair_count == $past(pair_count) + COUNT_W'(1))
    else $error("pair count did not advance");

  a_code_saved: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.ir_address == saved_address && result.ir_command == saved_command)
    else $error("reported code differs from saved code");

  a_no_take_stalled: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |-> !item_take)
    else $error("pair consumed while result stalled");

endmodule

@@ rtl/nec_ir_frame_decoder.sv @@
// Top level of the NEC IR frame decoder: input register, register file and decode core.
//
// Accepts one measured pulse pair per clock and reports one result per frame, on the pair
// flagged end_of_frame. A pair is registered in the input register and classified by
// combinational logic on its way into the result register, which loads when the core
// takes the pair. Sustained rate is one pair per cycle while no result is stalled. While
// a result waits unaccepted the core holds off; an empty input register still takes one
// more pair, then pair_ready drops. Timing references are written over APB
// at byte address 4*index and should only change while the block is idle.
module nec_ir_frame_decoder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nec_pkg::ADDR_W-1:0]  paddr,
  input  logic [nec_pkg::DATA_W-1:0]  pwdata,
  output logic [nec_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        pair_valid,
  output logic                        pair_ready,
  input  nec_pkg::pair_t              pair,
  output logic                        result_valid,
  input  logic                        result_ready,
  output nec_pkg::result_t            result
);
  import nec_pkg::*;

  cfg_t  cfg;
  logic  hold_valid;
  pair_t hold;
  logic  hold_take;

  assign pair_ready = !hold_valid || hold_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (pair_ready) begin
      hold_valid <= pair_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pair_valid && pair_ready) begin
      hold <= pair;
    end
  end

  nec_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  nec_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (hold_valid),
    .item         (hold),
    .item_take    (hold_take),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
